### design/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types, constants and microcode encoding for the binary min-heap
// priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

  // Default heap capacity and the number of significant key bytes.
  localparam int CAPACITY_DEF = 256;
  localparam int KEY_BYTES    = 8;
  localparam int KEY_W        = 64;
  localparam int ENTRY_W      = 9;
  localparam int STATUS_W     = 2;

  // Keys keep only their most significant KEY_BYTES bytes.
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (8 * (8 - KEY_BYTES));

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Input and result payloads.
  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]    removed_key;
    logic [KEY_W-1:0]    min_key;
    logic [ENTRY_W-1:0]  entry_count;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // Datapath micro-operations.
  typedef enum logic [4:0] {
    MOP_NOP,
    MOP_INS_INIT,
    MOP_READ_PARENT,
    MOP_UP_MOVE,
    MOP_INS_DONE,
    MOP_REM_INIT,
    MOP_TAKE_ROOT,
    MOP_LOAD_CUR,
    MOP_READ_LEFT,
    MOP_READ_RIGHT,
    MOP_PICK,
    MOP_PICK_LEFT,
    MOP_DN_MOVE,
    MOP_WRITE_CUR,
    MOP_SET_FULL,
    MOP_SET_EMPTY,
    MOP_READ_ROOT,
    MOP_EMIT
  } mop_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_IS_REMOVE,
    COND_EMPTY,
    COND_FULL,
    COND_POS_ZERO,
    COND_NO_LEFT,
    COND_NO_RIGHT,
    COND_CUR_GE_RD,
    COND_CUR_LE_PV
  } cond_t;

  // Microprogram addresses.
  localparam int UPC_W = 5;
  localparam logic [UPC_W-1:0] UPC_IDLE      = 5'd0;
  localparam logic [UPC_W-1:0] UPC_DISPATCH  = 5'd1;
  localparam logic [UPC_W-1:0] UPC_INS_CHK   = 5'd2;
  localparam logic [UPC_W-1:0] UPC_INS_INIT  = 5'd3;
  localparam logic [UPC_W-1:0] UPC_UP_TEST   = 5'd4;
  localparam logic [UPC_W-1:0] UPC_UP_READ   = 5'd5;
  localparam logic [UPC_W-1:0] UPC_UP_CMP    = 5'd6;
  localparam logic [UPC_W-1:0] UPC_UP_MOVE   = 5'd7;
  localparam logic [UPC_W-1:0] UPC_UP_PLACE  = 5'd8;
  localparam logic [UPC_W-1:0] UPC_REM       = 5'd9;
  localparam logic [UPC_W-1:0] UPC_REM_INIT  = 5'd10;
  localparam logic [UPC_W-1:0] UPC_TAKE_ROOT = 5'd11;
  localparam logic [UPC_W-1:0] UPC_LOAD_CUR  = 5'd12;
  localparam logic [UPC_W-1:0] UPC_DN_TEST   = 5'd13;
  localparam logic [UPC_W-1:0] UPC_DN_RIGHT  = 5'd14;
  localparam logic [UPC_W-1:0] UPC_DN_PICK   = 5'd15;
  localparam logic [UPC_W-1:0] UPC_DN_CMP    = 5'd16;
  localparam logic [UPC_W-1:0] UPC_DN_MOVE   = 5'd17;
  localparam logic [UPC_W-1:0] UPC_DN_ONE    = 5'd18;
  localparam logic [UPC_W-1:0] UPC_DN_PLACE  = 5'd19;
  localparam logic [UPC_W-1:0] UPC_FIN_FULL  = 5'd20;
  localparam logic [UPC_W-1:0] UPC_FIN_EMPTY = 5'd21;
  localparam logic [UPC_W-1:0] UPC_FIN       = 5'd22;
  localparam logic [UPC_W-1:0] UPC_EMIT      = 5'd23;

  // One control word of the microprogram.
  typedef struct packed {
    mop_t             mop;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  // Condition flags returned by the datapath.
  typedef struct packed {
    logic is_remove;
    logic empty;
    logic full;
    logic pos_zero;
    logic no_left;
    logic no_right;
    logic cur_ge_rd;
    logic cur_le_pv;
  } flags_t;

  // Builds one control word.
  function automatic ctrl_word_t mk_cw(mop_t mop, cond_t cond, logic [UPC_W-1:0] target);
    ctrl_word_t cw;
    cw.mop    = mop;
    cw.cond   = cond;
    cw.target = target;
    return cw;
  endfunction

endpackage

`default_nettype wire

### design/bmhq_ucode_rom.sv
// ----------------------------------------------------------------------------
// bmhq_ucode_rom
// Read-only microprogram: one control word for each step of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_ucode_rom (
  input  wire logic [bmhq_pkg::UPC_W-1:0] upc,
  output bmhq_pkg::ctrl_word_t            cw
);
  import bmhq_pkg::*;

  // Program table.
  always_comb begin
    case (upc)
      UPC_IDLE:      cw = mk_cw(MOP_NOP,         COND_NO_START,  UPC_IDLE);
      UPC_DISPATCH:  cw = mk_cw(MOP_NOP,         COND_IS_REMOVE, UPC_REM);
      UPC_INS_CHK:   cw = mk_cw(MOP_NOP,         COND_FULL,      UPC_FIN_FULL);
      UPC_INS_INIT:  cw = mk_cw(MOP_INS_INIT,    COND_NEVER,     UPC_IDLE);
      UPC_UP_TEST:   cw = mk_cw(MOP_NOP,         COND_POS_ZERO,  UPC_UP_PLACE);
      UPC_UP_READ:   cw = mk_cw(MOP_READ_PARENT, COND_NEVER,     UPC_IDLE);
      UPC_UP_CMP:    cw = mk_cw(MOP_NOP,         COND_CUR_GE_RD, UPC_UP_PLACE);
      UPC_UP_MOVE:   cw = mk_cw(MOP_UP_MOVE,     COND_ALWAYS,    UPC_UP_TEST);
      UPC_UP_PLACE:  cw = mk_cw(MOP_INS_DONE,    COND_ALWAYS,    UPC_FIN);
      UPC_REM:       cw = mk_cw(MOP_NOP,         COND_EMPTY,     UPC_FIN_EMPTY);
      UPC_REM_INIT:  cw = mk_cw(MOP_REM_INIT,    COND_NEVER,     UPC_IDLE);
      UPC_TAKE_ROOT: cw = mk_cw(MOP_TAKE_ROOT,   COND_NEVER,     UPC_IDLE);
      UPC_LOAD_CUR:  cw = mk_cw(MOP_LOAD_CUR,    COND_NEVER,     UPC_IDLE);
      UPC_DN_TEST:   cw = mk_cw(MOP_READ_LEFT,   COND_NO_LEFT,   UPC_DN_PLACE);
      UPC_DN_RIGHT:  cw = mk_cw(MOP_READ_RIGHT,  COND_NO_RIGHT,  UPC_DN_ONE);
      UPC_DN_PICK:   cw = mk_cw(MOP_PICK,        COND_NEVER,     UPC_IDLE);
      UPC_DN_CMP:    cw = mk_cw(MOP_NOP,         COND_CUR_LE_PV, UPC_DN_PLACE);
      UPC_DN_MOVE:   cw = mk_cw(MOP_DN_MOVE,     COND_ALWAYS,    UPC_DN_TEST);
      UPC_DN_ONE:    cw = mk_cw(MOP_PICK_LEFT,   COND_ALWAYS,    UPC_DN_CMP);
      UPC_DN_PLACE:  cw = mk_cw(MOP_WRITE_CUR,   COND_ALWAYS,    UPC_FIN);
      UPC_FIN_FULL:  cw = mk_cw(MOP_SET_FULL,    COND_ALWAYS,    UPC_FIN);
      UPC_FIN_EMPTY: cw = mk_cw(MOP_SET_EMPTY,   COND_NEVER,     UPC_IDLE);
      UPC_FIN:       cw = mk_cw(MOP_READ_ROOT,   COND_NEVER,     UPC_IDLE);
      UPC_EMIT:      cw = mk_cw(MOP_EMIT,        COND_ALWAYS,    UPC_IDLE);
      default:       cw = mk_cw(MOP_NOP,         COND_ALWAYS,    UPC_IDLE);
    endcase
  end

endmodule

`default_nettype wire

### design/bmhq_sequencer.sv
// ----------------------------------------------------------------------------
// bmhq_sequencer
// Step counter with conditional jumps that walks the microprogram.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_sequencer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  bmhq_pkg::flags_t          flags,
  output bmhq_pkg::ctrl_word_t      ctrl,
  output logic                      busy
);
  import bmhq_pkg::*;

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  logic             take;

  // Control word for the current step.
  bmhq_ucode_rom u_rom (
    .upc (upc_r),
    .cw  (ctrl)
  );

  // Jump condition and next step.
  always_comb begin
    case (ctrl.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_START:  take = !start;
      COND_IS_REMOVE: take = flags.is_remove;
      COND_EMPTY:     take = flags.empty;
      COND_FULL:      take = flags.full;
      COND_POS_ZERO:  take = flags.pos_zero;
      COND_NO_LEFT:   take = flags.no_left;
      COND_NO_RIGHT:  take = flags.no_right;
      COND_CUR_GE_RD: take = flags.cur_ge_rd;
      COND_CUR_LE_PV: take = flags.cur_le_pv;
      default:        take = 1'b1;
    endcase
    upc_nxt = take ? ctrl.target : upc_r + 1'b1;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign busy = (upc_r != UPC_IDLE);

endmodule

`default_nettype wire

### design/bmhq_datapath.sv
// ----------------------------------------------------------------------------
// bmhq_datapath
// Heap memory, working registers and comparators, driven by micro-operations.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_datapath #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  bmhq_pkg::in_item_t        in_item,
  input  bmhq_pkg::ctrl_word_t      ctrl,
  output bmhq_pkg::flags_t          flags,
  output logic                      out_valid,
  output bmhq_pkg::out_item_t       out_item
);
  import bmhq_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int POS_W  = ADDR_W + 2;
  localparam logic [POS_W-1:0] RD_LIMIT = POS_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  // Heap storage and its registered read port.
  logic [KEY_W-1:0] mem [CAPACITY];
  logic [KEY_W-1:0] rd_q;

  // Working registers.
  logic                op_r, op_nxt;
  logic [KEY_W-1:0]    cur_r, cur_nxt;
  logic [KEY_W-1:0]    lval_r, lval_nxt;
  logic [KEY_W-1:0]    pv_r, pv_nxt;
  logic [KEY_W-1:0]    removed_r, removed_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [ADDR_W-1:0]   parent_r, parent_nxt;
  logic [ADDR_W-1:0]   pick_r, pick_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  // Memory port controls.
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [KEY_W-1:0]  wr_data;
  logic              rd_req;
  logic              rd_en;
  logic [POS_W-1:0]  rd_full;

  // Addresses of the relatives of the current position.
  logic [POS_W-1:0]  left_full;
  logic [POS_W-1:0]  right_full;
  logic [POS_W-1:0]  count_ext;
  logic [ADDR_W-1:0] parent;

  assign left_full  = {1'b0, pos_r, 1'b1};
  assign right_full = left_full + 1'b1;
  assign count_ext  = POS_W'(count_r);
  assign parent     = (pos_r - 1'b1) >> 1;

  // Flags for the sequencer.
  assign flags.is_remove = (op_r == OP_REMOVE);
  assign flags.empty     = (count_r == '0);
  assign flags.full      = (count_r == CNT_FULL);
  assign flags.pos_zero  = (pos_r == '0);
  assign flags.no_left   = (left_full >= count_ext);
  assign flags.no_right  = (right_full >= count_ext);
  assign flags.cur_ge_rd = !(cur_r < rd_q);
  assign flags.cur_le_pv = !(cur_r > pv_r);

  // Micro-operation decode.
  always_comb begin
    op_nxt        = op_r;
    cur_nxt       = cur_r;
    lval_nxt      = lval_r;
    pv_nxt        = pv_r;
    removed_nxt   = removed_r;
    pos_nxt       = pos_r;
    parent_nxt    = parent_r;
    pick_nxt      = pick_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = cur_r;
    rd_req        = 1'b0;
    rd_full       = '0;

    case (ctrl.mop)
      MOP_NOP: begin
      end
      MOP_INS_INIT: begin
        pos_nxt = count_r[ADDR_W-1:0];
      end
      MOP_READ_PARENT: begin
        rd_req     = 1'b1;
        rd_full    = POS_W'(parent);
        parent_nxt = parent;
      end
      MOP_UP_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rd_q;
        pos_nxt = parent_r;
      end
      MOP_INS_DONE: begin
        wr_en     = 1'b1;
        count_nxt = count_r + 1'b1;
      end
      MOP_REM_INIT: begin
        rd_req    = 1'b1;
        count_nxt = count_r - 1'b1;
        pos_nxt   = '0;
      end
      MOP_TAKE_ROOT: begin
        removed_nxt = rd_q;
        rd_req      = 1'b1;
        rd_full     = POS_W'(count_r);
      end
      MOP_LOAD_CUR: begin
        cur_nxt = rd_q;
      end
      MOP_READ_LEFT: begin
        rd_req  = 1'b1;
        rd_full = left_full;
      end
      MOP_READ_RIGHT: begin
        lval_nxt = rd_q;
        rd_req   = 1'b1;
        rd_full  = right_full;
      end
      MOP_PICK: begin
        // Right child wins only when strictly smaller than the left.
        if (lval_r > rd_q) begin
          pv_nxt   = rd_q;
          pick_nxt = right_full[ADDR_W-1:0];
        end else begin
          pv_nxt   = lval_r;
          pick_nxt = left_full[ADDR_W-1:0];
        end
      end
      MOP_PICK_LEFT: begin
        pv_nxt   = lval_r;
        pick_nxt = left_full[ADDR_W-1:0];
      end
      MOP_DN_MOVE: begin
        wr_en   = 1'b1;
        wr_data = pv_r;
        pos_nxt = pick_r;
      end
      MOP_WRITE_CUR: begin
        wr_en = 1'b1;
      end
      MOP_SET_FULL: begin
        status_nxt = STATUS_FULL;
      end
      MOP_SET_EMPTY: begin
        status_nxt = STATUS_EMPTY;
      end
      MOP_READ_ROOT: begin
        rd_req = 1'b1;
      end
      MOP_EMIT: begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.removed_key = removed_r;
        out_item_nxt.min_key     = (count_r != '0) ? rd_q : '0;
        out_item_nxt.entry_count = ENTRY_W'(count_r);
        out_item_nxt.status      = status_r;
      end
      default: begin
      end
    endcase

    // A new item loads the working registers.
    if (accept) begin
      op_nxt      = in_item.operation;
      cur_nxt     = in_item.key & KEY_MASK;
      removed_nxt = '0;
      status_nxt  = STATUS_OK;
    end
  end

  // Reads beyond the store are dropped.
  assign rd_en = rd_req && (rd_full < RD_LIMIT);

  // Heap memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_full[ADDR_W-1:0]];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    cur_r      <= cur_nxt;
    lval_r     <= lval_nxt;
    pv_r       <= pv_nxt;
    removed_r  <= removed_nxt;
    pos_r      <= pos_nxt;
    parent_r   <= parent_nxt;
    pick_r     <= pick_nxt;
    status_r   <= status_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

### design/binary_min_heap_queue_core.sv
// An insert moves the key up until it reaches the root or meets a parent that is not
// greater; a remove moves the last key down until no child is left, a compare stops it
// or it moves to a lone left child; a remove on empty or insert on full makes no walk.
// One item at a time: the next transfer can come in the strobe cycle; every heap read
// goes through the single registered read port.
// Results cannot be stalled; reset clears the count and sequencer, not the heap contents.
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core
// Binary min-heap priority queue driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_queue_core #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  bmhq_pkg::in_item_t  in_item,
  output logic                out_valid,
  output bmhq_pkg::out_item_t out_item
);
  import bmhq_pkg::*;

  ctrl_word_t ctrl;
  flags_t     flags;
  logic       accept;

  // An item transfers when start meets an idle sequencer.
  assign accept = start && !busy;

  // Microprogram sequencer.
  bmhq_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // Heap datapath.
  bmhq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .ctrl      (ctrl),
    .flags     (flags),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after a transfer");

  // A result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A failed operation removes nothing.
  a_fail_no_removed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != STATUS_OK)) |-> (out_item.removed_key == '0))
    else $error("removed key set on a failed operation");

  // An empty queue reports a zero minimum.
  a_empty_min_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.entry_count == '0)) |-> (out_item.min_key == '0))
    else $error("nonzero minimum on an empty queue");

endmodule

`default_nettype wire
